### rtl/core/psgtd_pkg.sv
// Shared constants, codes and controller/datapath interface types of the tone divisor block.
package psgtd_pkg;

    localparam int unsigned PSG_CLOCK   = 3579545;
    localparam int unsigned TIMER_CLOCK = 1192380;

    localparam int DVD_W  = 21;
    localparam int DVS_W  = 17;
    localparam int CNT_W  = 5;
    localparam int PER_W  = 11;
    localparam int RATE_W = 17;
    localparam int DIV_W  = 16;
    localparam int NCH    = 4;

    localparam logic [DVD_W-1:0] RATE_DIVIDEND  = DVD_W'(PSG_CLOCK / 32);
    localparam logic [DVD_W-1:0] TIMER_DIVIDEND = DVD_W'(TIMER_CLOCK);
    localparam logic [CNT_W-1:0] DIV_LAST       = CNT_W'(DVD_W - 1);
    localparam logic [RATE_W-1:0] RATE_LIMIT    = RATE_W'(10000);
    localparam logic [PER_W-1:0] ZERO_PERIOD    = PER_W'(1024);

    localparam logic [PER_W-1:0] NOISE_PER [3] = '{PER_W'(16), PER_W'(32), PER_W'(64)};

    localparam logic [1:0] CH_NOISE = 2'd3;
    localparam logic [1:0] TONE2_CH = 2'd2;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_EVAL    = 2'd1;
    localparam logic [1:0] FUNC_SILENCE = 2'd2;

    localparam logic [2:0] REG_NOISE = 3'd6;
    localparam logic [1:0] NOISE_SEL_FOLLOW = 2'd3;

    localparam logic [1:0] GATE_NONE = 2'd0;
    localparam logic [1:0] GATE_ON   = 2'd1;
    localparam logic [1:0] GATE_OFF  = 2'd2;

    localparam logic [2:0] CFG_SOUND_EN = 3'd0;
    localparam logic [2:0] CFG_MASK     = 3'd1;
    localparam logic [2:0] CFG_PRIO0    = 3'd2;
    localparam logic [2:0] CFG_PRIO1    = 3'd3;
    localparam logic [2:0] CFG_PRIO2    = 3'd4;
    localparam logic [2:0] CFG_PRIO3    = 3'd5;

    localparam logic [1:0] PER_ITEM   = 2'd0;
    localparam logic [1:0] PER_NOISE  = 2'd1;
    localparam logic [1:0] PER_TONE2  = 2'd2;
    localparam logic [1:0] PER_FOLLOW = 2'd3;

    localparam logic DIV_RATE  = 1'b0;
    localparam logic DIV_TIMER = 1'b1;

    typedef struct packed {
        logic       latch;
        logic       att_wr;
        logic       per_load;
        logic [1:0] per_src;
        logic       flag_set;
        logic       flag_clr;
        logic       div_start;
        logic       div_sel;
        logic       rate_wr;
        logic       div_wr;
        logic       div_clr;
        logic       silence;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_idx;
        logic [1:0] sel;
        logic       follow;
        logic       ch_is2;
        logic       div_done;
        logic       pick_ok;
        logic       out_free;
    } t_sts;

endpackage

### rtl/core/psg_to_single_tone_divisor.sv
// Work per word: silence or an ignored word goes straight to the result; an attenuation write or
// re-evaluation runs the timer division when a channel is picked; a tone or noise write runs a rate
// division before that, two when channel 2 drags noise along; the result is offered the cycle after.
// Every division runs through one shared restoring divider (one bit per cycle).
// One word in work at a time; a new one waits until the result is registered, held off by ready.
// Synchronous active-low reset loads state and sound registers, not operands or result fields.
// Top level: tone divisor picker for a four-channel sound generator.
module psg_to_single_tone_divisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [3:0]                    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [2:0]                    i_reg_index,
    input  logic [9:0]                    i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_load_divisor,
    output logic [psgtd_pkg::DIV_W-1:0]   o_divisor,
    output logic [1:0]                    o_gate,
    output logic                          o_playing
);

    psgtd_pkg::t_cmd cmd;
    psgtd_pkg::t_sts sts;

    psgtd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    psgtd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_reg_index    (i_reg_index),
        .i_value        (i_value),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_load_divisor (o_load_divisor),
        .o_divisor      (o_divisor),
        .o_gate         (o_gate),
        .o_playing      (o_playing)
    );

endmodule

### rtl/core/psgtd_div.sv
// Restoring serial divider, one quotient bit per cycle.
module psgtd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psgtd_pkg::DVD_W-1:0]   i_dividend,
    input  logic [psgtd_pkg::DVS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [psgtd_pkg::DVD_W-1:0]   o_quotient
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [psgtd_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [psgtd_pkg::DVD_W-1:0]   r_quo, n_quo;
    logic [psgtd_pkg::DVS_W-1:0]   r_rem, n_rem;
    logic [psgtd_pkg::DVS_W-1:0]   r_dvs, n_dvs;
    logic [psgtd_pkg::DVS_W:0]     rem_sh;
    logic [psgtd_pkg::DVS_W:0]     rem_sub;
    logic                          q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[psgtd_pkg::DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[psgtd_pkg::DVD_W-2:0], q_bit};
            n_rem = q_bit ? rem_sub[psgtd_pkg::DVS_W-1:0] : rem_sh[psgtd_pkg::DVS_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == psgtd_pkg::DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/psgtd_dp.sv
// Datapath: sound registers, channel rates, priority pick, divider and result register.
module psgtd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psgtd_pkg::t_cmd               i_cmd,
    output psgtd_pkg::t_sts               o_sts,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [3:0]                    i_cfg_data,
    input  logic [1:0]                    i_func,
    input  logic [2:0]                    i_reg_index,
    input  logic [9:0]                    i_value,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_load_divisor,
    output logic [psgtd_pkg::DIV_W-1:0]   o_divisor,
    output logic [1:0]                    o_gate,
    output logic                          o_playing
);

    logic                            r_sound_en;
    logic [psgtd_pkg::NCH-1:0]       r_mask;
    logic [2:0]                      r_prio [psgtd_pkg::NCH];

    logic [psgtd_pkg::RATE_W-1:0]    r_rate [psgtd_pkg::NCH];
    logic [psgtd_pkg::NCH-1:0]       r_high;
    logic [3:0]                      r_att [psgtd_pkg::NCH];
    logic [psgtd_pkg::PER_W-1:0]     r_tone2;
    logic                            r_follow;
    logic [psgtd_pkg::DIV_W-1:0]     r_last;
    logic                            r_play;

    logic [1:0]                      r_func;
    logic [2:0]                      r_reg;
    logic [9:0]                      r_val;
    logic [psgtd_pkg::DIV_W-1:0]     r_start;
    logic                            r_eval;
    logic                            r_sil;
    logic [1:0]                      r_ch;
    logic [psgtd_pkg::PER_W-1:0]     r_per;

    logic                            r_ov;
    logic                            r_out_load;
    logic [psgtd_pkg::DIV_W-1:0]     r_out_div;
    logic [1:0]                      r_out_gate;
    logic                            r_out_play;

    logic                            div_done;
    logic [psgtd_pkg::DVD_W-1:0]     quo;
    logic [psgtd_pkg::DVD_W-1:0]     dvd;
    logic [psgtd_pkg::DVS_W-1:0]     dvs;
    logic [psgtd_pkg::RATE_W-1:0]    q_rate;
    logic [psgtd_pkg::PER_W-1:0]     item_per;
    logic [psgtd_pkg::PER_W-1:0]     tone2_per;
    logic                            found;
    logic [psgtd_pkg::RATE_W-1:0]    pick_rate;
    logic [1:0]                      pch;
    logic                            changed;
    logic [1:0]                      fin_gate;
    logic                            fin_play;

    always_comb begin
        found     = 1'b0;
        pick_rate = '0;
        pch       = '0;
        for (int s = 0; s < psgtd_pkg::NCH; s++) begin
            pch = 2'(r_prio[s] - 3'd1);
            if (!found && r_prio[s] >= 3'd1 && r_prio[s] <= 3'd4) begin
                if (!r_high[pch] && r_att[pch] != 4'hF && r_mask[pch]) begin
                    found     = 1'b1;
                    pick_rate = r_rate[pch];
                end
            end
        end
    end

    assign dvd = (i_cmd.div_sel == psgtd_pkg::DIV_TIMER) ? psgtd_pkg::TIMER_DIVIDEND
                                                          : psgtd_pkg::RATE_DIVIDEND;
    assign dvs = (i_cmd.div_sel == psgtd_pkg::DIV_TIMER) ? pick_rate
                                                          : psgtd_pkg::DVS_W'(r_per);

    psgtd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign q_rate    = quo[psgtd_pkg::RATE_W-1:0];
    assign item_per  = (r_val == 10'd0) ? psgtd_pkg::ZERO_PERIOD : {1'b0, r_val};
    assign tone2_per = (r_tone2 == '0) ? psgtd_pkg::ZERO_PERIOD : r_tone2;

    assign changed  = r_eval && (r_last != r_start);
    assign fin_play = changed ? (r_last != '0) : r_play;
    always_comb begin
        fin_gate = psgtd_pkg::GATE_NONE;
        if (r_sil) begin
            fin_gate = psgtd_pkg::GATE_OFF;
        end else if (changed) begin
            if (r_last == '0) begin
                fin_gate = psgtd_pkg::GATE_OFF;
            end else if (r_start == '0) begin
                fin_gate = psgtd_pkg::GATE_ON;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_en <= 1'b1;
            r_mask     <= '1;
            r_prio[0]  <= 3'd4;
            r_prio[1]  <= 3'd3;
            r_prio[2]  <= 3'd2;
            r_prio[3]  <= 3'd1;
            for (int c = 0; c < psgtd_pkg::NCH; c++) begin
                r_rate[c] <= '0;
                r_att[c]  <= 4'hF;
            end
            r_high   <= '0;
            r_tone2  <= '0;
            r_follow <= 1'b0;
            r_last   <= '0;
            r_play   <= 1'b0;
            r_ov     <= 1'b0;
            r_eval   <= 1'b0;
            r_sil    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psgtd_pkg::CFG_SOUND_EN: r_sound_en <= i_cfg_data[0];
                    psgtd_pkg::CFG_MASK:     r_mask     <= i_cfg_data;
                    psgtd_pkg::CFG_PRIO0:    r_prio[0]  <= i_cfg_data[2:0];
                    psgtd_pkg::CFG_PRIO1:    r_prio[1]  <= i_cfg_data[2:0];
                    psgtd_pkg::CFG_PRIO2:    r_prio[2]  <= i_cfg_data[2:0];
                    psgtd_pkg::CFG_PRIO3:    r_prio[3]  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_eval <= 1'b0;
                r_sil  <= 1'b0;
            end
            if (i_cmd.att_wr) begin
                r_att[r_reg[2:1]] <= r_val[3:0];
            end
            if (i_cmd.per_load && i_cmd.per_src == psgtd_pkg::PER_ITEM &&
                r_reg[2:1] == psgtd_pkg::TONE2_CH) begin
                r_tone2 <= item_per;
            end
            if (i_cmd.flag_set) begin
                r_follow <= 1'b1;
            end
            if (i_cmd.flag_clr) begin
                r_follow <= 1'b0;
            end
            if (i_cmd.rate_wr) begin
                r_high[r_ch] <= (q_rate > psgtd_pkg::RATE_LIMIT);
                r_rate[r_ch] <= (r_ch == psgtd_pkg::CH_NOISE) ? (q_rate >> 2) : q_rate;
            end
            if (i_cmd.div_wr) begin
                r_last <= quo[psgtd_pkg::DIV_W-1:0];
                r_eval <= 1'b1;
            end
            if (i_cmd.div_clr) begin
                r_last <= '0;
                r_eval <= 1'b1;
            end
            if (i_cmd.silence) begin
                r_last <= '0;
                r_play <= 1'b0;
                r_sil  <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_play <= fin_play;
                r_ov   <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_reg   <= i_reg_index;
            r_val   <= i_value;
            r_start <= r_last;
        end
        if (i_cmd.per_load) begin
            case (i_cmd.per_src)
                psgtd_pkg::PER_ITEM: begin
                    r_ch  <= r_reg[2:1];
                    r_per <= item_per;
                end
                psgtd_pkg::PER_NOISE: begin
                    r_ch  <= psgtd_pkg::CH_NOISE;
                    r_per <= psgtd_pkg::NOISE_PER[r_val[1:0]];
                end
                psgtd_pkg::PER_TONE2: begin
                    r_ch  <= psgtd_pkg::CH_NOISE;
                    r_per <= tone2_per;
                end
                default: begin
                    r_ch <= psgtd_pkg::CH_NOISE;
                end
            endcase
        end
        if (i_cmd.fin) begin
            r_out_load <= changed && (r_last != '0);
            r_out_div  <= r_last;
            r_out_gate <= fin_gate;
            r_out_play <= fin_play;
        end
    end

    always_comb begin
        o_sts.func     = r_func;
        o_sts.reg_idx  = r_reg;
        o_sts.sel      = r_val[1:0];
        o_sts.follow   = r_follow;
        o_sts.ch_is2   = (r_ch == psgtd_pkg::TONE2_CH);
        o_sts.div_done = div_done;
        o_sts.pick_ok  = r_sound_en && found && (pick_rate != '0);
        o_sts.out_free = !r_ov || i_ready;
    end

    assign o_valid        = r_ov;
    assign o_load_divisor = r_out_load;
    assign o_divisor      = r_out_div;
    assign o_gate         = r_out_gate;
    assign o_playing      = r_out_play;

`ifndef NO_ASSERTIONS
    a_load_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_load) |-> (r_out_div != '0))
        else $error("load word with zero divisor");
    a_gate_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_gate == psgtd_pkg::GATE_ON) |-> r_out_load)
        else $error("speaker on without divisor load");
    a_play_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out_play == (r_out_div != '0)))
        else $error("playing flag disagrees with divisor");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (!r_ov || i_ready))
        else $error("result word overwritten");
`endif

endmodule

### rtl/core/psgtd_ctrl.sv
// Controller: sequences register updates, rate and timer divisions and result hand-off.
module psgtd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  psgtd_pkg::t_sts   i_sts,
    output psgtd_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_RSTART = 3'd2;
    localparam logic [2:0] S_RWAIT  = 3'd3;
    localparam logic [2:0] S_ESTART = 3'd4;
    localparam logic [2:0] S_EWAIT  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.func)
                    psgtd_pkg::FUNC_WRITE: begin
                        if (i_sts.reg_idx == psgtd_pkg::REG_NOISE) begin
                            if (i_sts.sel == psgtd_pkg::NOISE_SEL_FOLLOW) begin
                                if (i_sts.follow) begin
                                    n_state = S_FIN;
                                end else begin
                                    o_cmd.flag_set = 1'b1;
                                    o_cmd.per_load = 1'b1;
                                    o_cmd.per_src  = psgtd_pkg::PER_TONE2;
                                    n_state        = S_RSTART;
                                end
                            end else begin
                                o_cmd.flag_clr = 1'b1;
                                o_cmd.per_load = 1'b1;
                                o_cmd.per_src  = psgtd_pkg::PER_NOISE;
                                n_state        = S_RSTART;
                            end
                        end else if (i_sts.reg_idx[0]) begin
                            o_cmd.att_wr = 1'b1;
                            n_state      = S_ESTART;
                        end else begin
                            o_cmd.per_load = 1'b1;
                            o_cmd.per_src  = psgtd_pkg::PER_ITEM;
                            n_state        = S_RSTART;
                        end
                    end
                    psgtd_pkg::FUNC_EVAL: begin
                        n_state = S_ESTART;
                    end
                    psgtd_pkg::FUNC_SILENCE: begin
                        o_cmd.silence = 1'b1;
                        n_state       = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_RSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = psgtd_pkg::DIV_RATE;
                n_state         = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_wr = 1'b1;
                    if (i_sts.ch_is2 && i_sts.follow) begin
                        o_cmd.per_load = 1'b1;
                        o_cmd.per_src  = psgtd_pkg::PER_FOLLOW;
                        n_state        = S_RSTART;
                    end else begin
                        n_state = S_ESTART;
                    end
                end
            end
            S_ESTART: begin
                if (i_sts.pick_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = psgtd_pkg::DIV_TIMER;
                    n_state         = S_EWAIT;
                end else begin
                    o_cmd.div_clr = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_EWAIT: begin
                o_cmd.div_sel = psgtd_pkg::DIV_TIMER;
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
